// ===== src/pddm_pkg.sv =====
// Shared types and constants for the PID differential-drive mixer.
`default_nettype none

package pddm_pkg;

    // Stream and configuration widths
    localparam int unsigned InDataWidth  = 16;
    localparam int unsigned OutDataWidth = 32;
    localparam int unsigned CfgIdxWidth  = 3;
    localparam int unsigned CfgDataWidth = 32;
    localparam int unsigned FracBits     = 24;

    // Motor command ceiling
    localparam logic [7:0] SpeedMax = 8'd250;

    // Configuration register indexes
    typedef enum logic [CfgIdxWidth-1:0] {
        REG_TARGET_POSITION     = 3'd0,
        REG_BASE_SPEED          = 3'd1,
        REG_GAIN_P              = 3'd2,
        REG_GAIN_I_TIMES_PERIOD = 3'd3,
        REG_GAIN_D_OVER_PERIOD  = 3'd4
    } cfg_index_t;

    // Reset values of the configuration registers
    localparam logic [15:0] TargetReset = 16'sd0;
    localparam logic [7:0]  BaseReset   = 8'd100;
    localparam logic [31:0] GainPReset  = 32'd1900544;
    localparam logic [31:0] GainIReset  = 32'd0;
    localparam logic [31:0] GainDReset  = 32'd3276800;

    // Error stage result: error, updated integral, error difference (all Q8.8)
    typedef struct packed {
        logic [16:0] err;
        logic [31:0] err_sum;
        logic [17:0] err_diff;
    } err_stage_t;

    // Product stage result: the three PID terms in Q.24
    typedef struct packed {
        logic [48:0] p_term;
        logic [63:0] i_term;
        logic [49:0] d_term;
    } prod_stage_t;

    // Output beat fields
    typedef struct packed {
        logic [15:0] correction;
        logic [7:0]  right_speed;
        logic [7:0]  left_speed;
    } result_t;

endpackage

`default_nettype wire

// ===== src/pddm_error.sv =====
// Error stage: forms the error, the saturated integral and the difference term.
`default_nettype none

module pddm_error
    import pddm_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [15:0] pos,
    input  wire logic [15:0] target_position,
    output logic             out_valid,
    input  wire logic        out_ready,
    output err_stage_t       out_data
);

    logic              valid_reg;
    err_stage_t        data_reg;
    err_stage_t        data_next;
    logic signed [31:0] error_sum_reg;
    logic signed [16:0] last_error_reg;
    logic signed [16:0] err;
    logic signed [32:0] sum_wide;
    logic signed [31:0] sum_sat;
    logic              load;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    // Error, saturating integral and difference against the previous error
    always_comb begin
        err      = $signed({target_position[15], target_position})
                 - $signed({pos[15], pos});
        sum_wide = $signed({error_sum_reg[31], error_sum_reg})
                 + $signed({{16{err[16]}}, err});
        if (sum_wide[32] != sum_wide[31]) begin
            sum_sat = sum_wide[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
        end else begin
            sum_sat = sum_wide[31:0];
        end
        data_next.err      = err;
        data_next.err_sum  = sum_sat;
        data_next.err_diff = $signed({err[16], err})
                           - $signed({last_error_reg[16], last_error_reg});
    end

    // Advance the stage and commit the controller state on each beat taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= 1'b0;
            error_sum_reg  <= '0;
            last_error_reg <= '0;
        end else begin
            if (in_ready) begin
                valid_reg <= in_valid;
            end
            if (load) begin
                error_sum_reg  <= sum_sat;
                last_error_reg <= err;
            end
        end
    end

    // Hold payload
    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// ===== src/pddm_product.sv =====
// Product stage: multiplies each PID operand by its gain.
`default_nettype none

module pddm_product
    import pddm_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire err_stage_t  in_data,
    input  wire logic [31:0] gain_p,
    input  wire logic [31:0] gain_i_times_period,
    input  wire logic [31:0] gain_d_over_period,
    output logic             out_valid,
    input  wire logic        out_ready,
    output prod_stage_t      out_data
);

    logic        valid_reg;
    prod_stage_t data_reg;
    prod_stage_t data_next;
    logic        load;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    // Three exact signed products, Q16.16 by Q8.8
    always_comb begin
        data_next.p_term = $signed(gain_p) * $signed(in_data.err);
        data_next.i_term = $signed(gain_i_times_period) * $signed(in_data.err_sum);
        data_next.d_term = $signed(gain_d_over_period) * $signed(in_data.err_diff);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    // Hold payload
    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// ===== src/pddm_accum.sv =====
// Accumulate stage: sums the three PID terms into the Q.24 correction.
`default_nettype none

module pddm_accum
    import pddm_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire prod_stage_t in_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [63:0]      out_acc
);

    logic        valid_reg;
    logic [63:0] acc_reg;
    logic [63:0] acc_next;
    logic        load;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    // Sign-extend and add; the total stays inside 64 bits
    assign acc_next = {{15{in_data.p_term[48]}}, in_data.p_term}
                    + in_data.i_term
                    + {{14{in_data.d_term[49]}}, in_data.d_term};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    // Hold payload
    always_ff @(posedge aclk) begin
        if (load) begin
            acc_reg <= acc_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_acc   = acc_reg;

endmodule

`default_nettype wire

// ===== src/pddm_mix.sv =====
// Mix stage: forms both motor speeds and the whole-number correction.
`default_nettype none

module pddm_mix
    import pddm_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [63:0] in_acc,
    input  wire logic [7:0]  base_speed,
    output logic             out_valid,
    input  wire logic        out_ready,
    output result_t          out_data
);

    logic               valid_reg;
    result_t            data_reg;
    result_t            data_next;
    logic               load;
    logic signed [64:0] thr;
    logic signed [64:0] acc_ext;
    logic signed [64:0] right_q24;
    logic signed [64:0] left_q24;
    logic signed [39:0] corr_floor;
    logic signed [39:0] corr_trunc;
    logic               round_up;

    // Clamp a Q.24 speed to 0..SpeedMax, truncating the fraction
    function automatic logic [7:0] clamp_speed(input logic signed [64:0] v);
        logic [7:0] s;
        if (v[64] || v == '0) begin
            s = 8'd0;
        end else if (v[64:FracBits] > {33'd0, SpeedMax}) begin
            s = SpeedMax;
        end else begin
            s = v[FracBits+7:FracBits];
        end
        return s;
    endfunction

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_comb begin
        thr        = $signed({33'd0, base_speed, 24'd0});
        acc_ext    = $signed({in_acc[63], in_acc});
        right_q24  = thr + acc_ext;
        left_q24   = thr - acc_ext;
        // Round the correction toward zero, then saturate to 16 bits
        corr_floor = $signed(in_acc[63:FracBits]);
        round_up   = in_acc[63] && (in_acc[FracBits-1:0] != '0);
        corr_trunc = corr_floor + $signed({39'd0, round_up});
        if (corr_trunc > 40'sd32767) begin
            data_next.correction = 16'h7fff;
        end else if (corr_trunc < -40'sd32768) begin
            data_next.correction = 16'h8000;
        end else begin
            data_next.correction = corr_trunc[15:0];
        end
        // Zero throttle stops both motors
        if (base_speed == 8'd0) begin
            data_next.right_speed = 8'd0;
            data_next.left_speed  = 8'd0;
        end else begin
            data_next.right_speed = clamp_speed(right_q24);
            data_next.left_speed  = clamp_speed(left_q24);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    // Hold payload
    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// ===== src/pid_differential_drive_mixer_top.sv =====
// Top level: configuration registers, input register and the stage chain.
// A result beat passes the input register, then the error, product, accumulate and mix stage registers.
// Throughput: one beat per cycle while m_tready is high; each stage holds one beat and refills as it empties.
// The integral and previous-error state update as a beat leaves the input register.
// Reset (aresetn low, synchronous) empties every stage, clears the controller
// state and returns the configuration registers to their default values.
`default_nettype none

module pid_differential_drive_mixer_top
    import pddm_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    // Input stream; s_tdata: [15:0] measured_position
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire logic [InDataWidth-1:0]  s_tdata,
    // Result stream; m_tdata: [7:0] left_speed, [15:8] right_speed, [31:16] correction
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    output logic [OutDataWidth-1:0]      m_tdata,
    // Configuration write port
    input  wire logic                    cfg_we,
    input  wire logic [CfgIdxWidth-1:0]  cfg_index,
    input  wire logic [CfgDataWidth-1:0] cfg_wdata
);

    logic [15:0]  target_position_reg;
    logic [7:0]   base_speed_reg;
    logic [31:0]  gain_p_reg;
    logic [31:0]  gain_i_reg;
    logic [31:0]  gain_d_reg;

    logic         in_valid_reg;
    logic [15:0]  pos_reg;
    logic         in_load;

    logic         err_ready;
    logic         err_valid;
    err_stage_t   err_data;
    logic         prod_ready;
    logic         prod_valid;
    prod_stage_t  prod_data;
    logic         acc_ready;
    logic         acc_valid;
    logic [63:0]  acc_data;
    logic         mix_ready;
    result_t      mix_data;

    // Configuration registers; unknown indexes are ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_position_reg <= TargetReset;
            base_speed_reg      <= BaseReset;
            gain_p_reg          <= GainPReset;
            gain_i_reg          <= GainIReset;
            gain_d_reg          <= GainDReset;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_TARGET_POSITION:     target_position_reg <= cfg_wdata[15:0];
                REG_BASE_SPEED:          base_speed_reg      <= cfg_wdata[7:0];
                REG_GAIN_P:              gain_p_reg          <= cfg_wdata;
                REG_GAIN_I_TIMES_PERIOD: gain_i_reg          <= cfg_wdata;
                REG_GAIN_D_OVER_PERIOD:  gain_d_reg          <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Input register
    assign s_tready = !in_valid_reg || err_ready;
    assign in_load  = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load) begin
            pos_reg <= s_tdata[15:0];
        end
    end

    pddm_error u_error (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_valid        (in_valid_reg),
        .in_ready        (err_ready),
        .pos             (pos_reg),
        .target_position (target_position_reg),
        .out_valid       (err_valid),
        .out_ready       (prod_ready),
        .out_data        (err_data)
    );

    pddm_product u_product (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .in_valid            (err_valid),
        .in_ready            (prod_ready),
        .in_data             (err_data),
        .gain_p              (gain_p_reg),
        .gain_i_times_period (gain_i_reg),
        .gain_d_over_period  (gain_d_reg),
        .out_valid           (prod_valid),
        .out_ready           (acc_ready),
        .out_data            (prod_data)
    );

    pddm_accum u_accum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (prod_valid),
        .in_ready  (acc_ready),
        .in_data   (prod_data),
        .out_valid (acc_valid),
        .out_ready (mix_ready),
        .out_acc   (acc_data)
    );

    pddm_mix u_mix (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (acc_valid),
        .in_ready   (mix_ready),
        .in_acc     (acc_data),
        .base_speed (base_speed_reg),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (mix_data)
    );

    assign m_tdata = mix_data;

endmodule

`default_nettype wire

// ===== src/pddm_checker.sv =====
// Port-level checker for the mixer, bound to the top level.
`default_nettype none

module pddm_checker
    import pddm_pkg::*;
(
    input wire logic                    aclk,
    input wire logic                    aresetn,
    input wire logic                    m_tvalid,
    input wire logic                    m_tready,
    input wire logic [OutDataWidth-1:0] m_tdata
);

    result_t res;
    assign res = m_tdata;

    // A stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid straight after reset");

    // Speeds never exceed the ceiling
    a_speed_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> res.left_speed <= SpeedMax && res.right_speed <= SpeedMax)
        else $error("motor speed above ceiling");

    // A positive correction cannot slow the right motor below the left
    a_steer_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !res.correction[15] && res.correction != '0
            |-> res.right_speed >= res.left_speed)
        else $error("right speed below left for positive correction");

    // A negative correction cannot slow the left motor below the right
    a_steer_neg: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res.correction[15] |-> res.left_speed >= res.right_speed)
        else $error("left speed below right for negative correction");

endmodule

bind pid_differential_drive_mixer_top pddm_checker u_pddm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the PID differential-drive mixer top level.
`timescale 1ns / 1ps

module testbench;
    import pddm_pkg::*;

    localparam int          ResetCycles = 11;
    localparam int          TailCycles  = 16;
    localparam longint      CycleLimit  = 4_000_000;
    localparam int          RandPhases  = 5;
    localparam int          PhaseItems  = 80;
    // Runs of full-scale errors that swing the integral far each way
    localparam int          SatRunHigh  = 40;
    localparam int          SatRunLow   = 80;
    localparam int          PrintCap    = 50;
    localparam logic [15:0] PosMax      = 16'h7FFF;
    localparam logic [15:0] PosMin      = 16'h8000;
    localparam logic [31:0] GainMax     = 32'h7FFF_FFFF;
    localparam logic [31:0] GainMin     = 32'h8000_0000;
    localparam longint      OneQ24      = 64'sd1 <<< FracBits;
    localparam longint      SumMax      = 64'sd2147483647;
    localparam longint      SumMin      = -64'sd2147483648;
    localparam longint      CorrMax     = 64'sd32767;
    localparam longint      CorrMin     = -64'sd32768;

    logic                    aclk      = 1'b0;
    logic                    aresetn   = 1'b0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic [InDataWidth-1:0]  s_tdata   = '0;
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    logic [OutDataWidth-1:0] m_tdata;
    logic                    cfg_we    = 1'b0;
    logic [CfgIdxWidth-1:0]  cfg_index = '0;
    logic [CfgDataWidth-1:0] cfg_wdata = '0;

    // Controller copy: settings and loop state as the block should hold them
    logic signed [15:0] tgt_pos  = TargetReset;
    logic        [7:0]  throttle = BaseReset;
    logic signed [31:0] kp       = GainPReset;
    logic signed [31:0] ki_t     = GainIReset;
    logic signed [31:0] kd_t     = GainDReset;
    logic signed [31:0] integral = '0;
    logic signed [16:0] prev_err = '0;

    result_t motor_cmd_q[$];
    bit      gaps_on         = 1'b1;
    int      mismatches      = 0;
    int      beats_sent      = 0;
    int      results_checked = 0;
    int      reg_writes      = 0;
    longint  cycles          = 0;

    pid_differential_drive_mixer_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always #4 aclk = ~aclk;

    // Abort a hung run
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, motor_cmd_q.size());
            $display("tb: failure");
            $finish;
        end
    end

    // Truncate a Q.24 motor command and clamp it to the speed range
    function automatic logic [7:0] clamp_speed(input longint q24);
        longint whole;
        if (q24 <= 0) return '0;
        whole = q24 >>> FracBits;
        if (whole > longint'(SpeedMax)) whole = longint'(SpeedMax);
        return whole[7:0];
    endfunction

    // One control tick: update the integral and previous error, mix the motors
    function automatic result_t compute_motor_cmd(input logic signed [15:0] pos);
        longint  err, sum, acc, thr, corr;
        result_t cmd;
        err = longint'(tgt_pos) - longint'(pos);
        sum = longint'(integral) + err;
        if (sum > SumMax) sum = SumMax;
        if (sum < SumMin) sum = SumMin;
        acc = longint'(kp) * err + longint'(ki_t) * sum
            + longint'(kd_t) * (err - longint'(prev_err));
        integral = sum[31:0];
        prev_err = err[16:0];
        thr = longint'(throttle) <<< FracBits;
        if (throttle == '0) begin
            cmd.left_speed  = '0;
            cmd.right_speed = '0;
        end else begin
            cmd.right_speed = clamp_speed(thr + acc);
            cmd.left_speed  = clamp_speed(thr - acc);
        end
        corr = acc / OneQ24;
        if (corr > CorrMax) corr = CorrMax;
        if (corr < CorrMin) corr = CorrMin;
        cmd.correction = corr[15:0];
        return cmd;
    endfunction

    function automatic void apply_reg(input logic [CfgIdxWidth-1:0]  idx,
                                      input logic [CfgDataWidth-1:0] value);
        case (idx)
            REG_TARGET_POSITION:     tgt_pos  = value[15:0];
            REG_BASE_SPEED:          throttle = value[7:0];
            REG_GAIN_P:              kp       = value;
            REG_GAIN_I_TIMES_PERIOD: ki_t     = value;
            REG_GAIN_D_OVER_PERIOD:  kd_t     = value;
            default: ;
        endcase
    endfunction

    // Mostly no gap, often a short one, now and then a long one
    function automatic int pick_gap();
        int roll;
        if (!gaps_on) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 94) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Full-scale now and then, otherwise scaled down to usable magnitudes
    function automatic logic [31:0] rand_gain();
        logic [31:0] raw;
        raw = $urandom;
        if ($urandom_range(0, 3) == 0) return raw;
        return $signed(raw) >>> $urandom_range(6, 26);
    endfunction

    // Junk in the upper bits; throttle zero, at or above the ceiling, or in between
    function automatic logic [31:0] rand_throttle_word();
        logic [31:0] word;
        word = $urandom;
        case ($urandom_range(0, 7))
            0:       word[7:0] = '0;
            1:       word[7:0] = 8'($urandom_range(250, 255));
            default: word[7:0] = 8'($urandom_range(1, 249));
        endcase
        return word;
    endfunction

    // Mostly near the setpoint, sometimes anywhere
    function automatic logic [15:0] rand_position();
        if ($urandom_range(0, 3) == 0) return 16'($urandom);
        return 16'(int'(tgt_pos) + int'($urandom_range(0, 1023)) - 512);
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        if (mismatches <= PrintCap)
            $display("mismatch at result %0d: %s got %0d, want %0d",
                     results_checked, what, got, want);
    endtask

    task automatic check_motor_cmd(input result_t got);
        result_t want;
        results_checked++;
        if (motor_cmd_q.size() == 0) begin
            report_mismatch("result with nothing pending", longint'(got), 0);
            return;
        end
        want = motor_cmd_q.pop_front();
        if (got.left_speed !== want.left_speed)
            report_mismatch("left_speed", got.left_speed, want.left_speed);
        if (got.right_speed !== want.right_speed)
            report_mismatch("right_speed", got.right_speed, want.right_speed);
        if (got.correction !== want.correction)
            report_mismatch("correction", $signed(got.correction), $signed(want.correction));
    endtask

    // Compare every result beat with the oldest pending command
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) check_motor_cmd(m_tdata);
    end

    // Result side: runs of ready broken by random stalls
    initial begin : result_sink
        int run;
        int gap;
        @(posedge aclk);
        forever begin
            run = $urandom_range(1, 12);
            m_tready <= 1'b1;
            repeat (run) @(posedge aclk);
            gap = pick_gap();
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    end

    // Offer one position beat, hold it until taken, then predict its result
    task automatic send_position(input logic [15:0] pos);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pos;
        do @(posedge aclk); while (!s_tready);
        motor_cmd_q.push_back(compute_motor_cmd(pos));
        beats_sent++;
    endtask

    // Hold the input idle until every pending result has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (motor_cmd_q.size() != 0) @(posedge aclk);
    endtask

    // Only called with the input idle and nothing pending
    task automatic write_reg(input logic [CfgIdxWidth-1:0]  idx,
                             input logic [CfgDataWidth-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        apply_reg(idx, value);
        reg_writes++;
        @(posedge aclk);
    endtask

    task automatic test_reset_defaults();
        send_position(16'h0000);
        send_position(PosMax);
        send_position(PosMin);
    endtask

    // Largest errors and error swings against full-scale gains
    task automatic test_error_extremes();
        wait_drained();
        write_reg(REG_TARGET_POSITION, {16'h0000, PosMax});
        write_reg(REG_GAIN_P, GainMax);
        write_reg(REG_GAIN_I_TIMES_PERIOD, GainMin);
        write_reg(REG_GAIN_D_OVER_PERIOD, GainMax);
        send_position(PosMin);
        send_position(PosMin);
        wait_drained();
        write_reg(REG_TARGET_POSITION, {16'hFFFF, PosMin});
        write_reg(REG_GAIN_P, GainMin);
        write_reg(REG_GAIN_D_OVER_PERIOD, GainMin);
        send_position(PosMax);
        send_position(PosMax);
    endtask

    // Motors stay stopped while the correction still comes out
    task automatic test_zero_throttle();
        wait_drained();
        write_reg(REG_TARGET_POSITION, 32'd0);
        write_reg(REG_BASE_SPEED, 32'hA5A5_A500);
        write_reg(REG_GAIN_P, GainPReset);
        write_reg(REG_GAIN_I_TIMES_PERIOD, 32'd0);
        write_reg(REG_GAIN_D_OVER_PERIOD, 32'd0);
        send_position(16'h0100);
        send_position(16'hFF00);
    endtask

    // Throttle above the ceiling, and the ceiling itself with a correction
    task automatic test_throttle_ceiling();
        wait_drained();
        write_reg(REG_BASE_SPEED, 32'd255);
        send_position(16'h0000);
        wait_drained();
        write_reg(REG_BASE_SPEED, {24'h0, SpeedMax});
        send_position(16'h0080);
        send_position(16'hFF80);
    endtask

    // Sub-unit corrections truncate; a negative motor value gives zero
    task automatic test_truncation();
        wait_drained();
        write_reg(REG_BASE_SPEED, 32'd100);
        write_reg(REG_GAIN_P, 32'd1);
        write_reg(REG_TARGET_POSITION, 32'd1);
        send_position(16'h0000);
        send_position(16'h0002);
        wait_drained();
        write_reg(REG_BASE_SPEED, 32'd1);
        write_reg(REG_GAIN_P, 32'h0001_8000);
        write_reg(REG_TARGET_POSITION, 32'd0);
        send_position(16'h0100);
        send_position(16'hFF00);
    endtask

    // Writes to unused indexes must leave every setting alone
    task automatic test_unknown_index();
        wait_drained();
        write_reg(REG_BASE_SPEED, 32'd120);
        write_reg(REG_GAIN_D_OVER_PERIOD, GainDReset);
        for (int idx = int'(REG_GAIN_D_OVER_PERIOD) + 1; idx < (1 << CfgIdxWidth); idx++)
            write_reg(CfgIdxWidth'(idx), $urandom);
        send_position(16'h0180);
        send_position(16'hFE00);
    endtask

    // Random settings per phase; one phase runs with no stalls at all
    task automatic test_random_settings();
        for (int phase = 0; phase < RandPhases; phase++) begin
            wait_drained();
            gaps_on = (phase != 2);
            write_reg(REG_TARGET_POSITION, $urandom);
            write_reg(REG_BASE_SPEED, rand_throttle_word());
            write_reg(REG_GAIN_P, rand_gain());
            write_reg(REG_GAIN_I_TIMES_PERIOD, rand_gain());
            write_reg(REG_GAIN_D_OVER_PERIOD, rand_gain());
            repeat (PhaseItems) send_position(rand_position());
        end
        gaps_on = 1'b1;
    endtask

    // Drive the integral far upwards, then swing it far downwards
    task automatic test_integral_runs();
        wait_drained();
        gaps_on = 1'b0;
        write_reg(REG_BASE_SPEED, 32'd128);
        write_reg(REG_GAIN_P, 32'd0);
        write_reg(REG_GAIN_I_TIMES_PERIOD, 32'h0000_0040);
        write_reg(REG_GAIN_D_OVER_PERIOD, 32'd0);
        write_reg(REG_TARGET_POSITION, {16'h0000, PosMax});
        repeat (SatRunHigh) send_position(PosMin);
        // full-scale gains against a large integral
        wait_drained();
        write_reg(REG_GAIN_P, GainMax);
        write_reg(REG_GAIN_I_TIMES_PERIOD, GainMin);
        write_reg(REG_GAIN_D_OVER_PERIOD, GainMin);
        send_position(PosMin);
        send_position(16'h0000);
        wait_drained();
        write_reg(REG_GAIN_P, 32'd0);
        write_reg(REG_GAIN_I_TIMES_PERIOD, 32'h0000_0040);
        write_reg(REG_GAIN_D_OVER_PERIOD, 32'd0);
        write_reg(REG_TARGET_POSITION, {16'hFFFF, PosMin});
        repeat (SatRunLow) send_position(PosMax);
        gaps_on = 1'b1;
    endtask

    initial begin
        repeat (ResetCycles) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_defaults();
        test_error_extremes();
        test_zero_throttle();
        test_throttle_ceiling();
        test_truncation();
        test_unknown_index();
        test_random_settings();
        test_integral_runs();
        wait_drained();
        repeat (TailCycles) @(posedge aclk);
        if (motor_cmd_q.size() != 0)
            report_mismatch("results never returned", motor_cmd_q.size(), 0);
        $display("covered: %0d position beats, %0d results compared, %0d register writes",
                 beats_sent, results_checked, reg_writes);
        $display("covered: extreme errors/gains, zero and high throttle, long integral runs");
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
